### rtl/assert_macros.svh
// assertion macros shared by the checker files of the tile planner
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define GTSP_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tile planner assertion failed");

// next-cycle implication, disabled while reset is asserted
`define GTSP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tile planner assertion failed");

`endif

### rtl/gtsp_pkg.sv
// shared widths, defaults, command/status types and helpers of the tile planner
// no dependencies
`timescale 1ns / 1ps

package gtsp_pkg;

	localparam int DIM_W    = 9;
	localparam int BUDGET_W = 20;
	localparam int JOB_W    = 12;
	localparam int DIV_W    = DIM_W + 1;
	localparam int PROD_W   = 2 * DIM_W;
	localparam int NEED_W   = PROD_W + 4;
	localparam int WORK_W   = 3 * DIM_W;

	localparam logic [JOB_W-1:0] JOB_MAX = {JOB_W{1'b1}};
	localparam int ACC_BYTES = 4;

	localparam int PE_DIM_DEF    = 16;
	localparam int K_STEP_DEF    = 32;
	localparam int ALIGN_PAD_DEF = 64;
	localparam int MAX_DIM_DEF   = 256;

	typedef enum logic [1:0] {
		SEL_M,
		SEL_N,
		SEL_K
	} dim_sel_t;

	typedef struct packed {
		logic     load;
		logic     step;
		logic     div_start;
		dim_sel_t div_sel;
		logic     mul;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic invalid;
		logic last_cand;
		logic pipe_busy;
		logic found;
		logic div_done;
	} status_t;

	// first candidate tile size: the step, or the whole dimension if smaller
	function automatic logic [DIM_W-1:0] cand_first(input logic [DIM_W-1:0] dim,
			input logic [DIM_W:0] step);
		return (step < {1'b0, dim}) ? step[DIM_W-1:0] : dim;
	endfunction

	// next candidate: one step up, clipped to the whole dimension
	function automatic logic [DIM_W-1:0] cand_next(input logic [DIM_W-1:0] cur,
			input logic [DIM_W-1:0] dim, input logic [DIM_W:0] step);
		logic [DIM_W:0] nx;
		nx = {1'b0, cur} + step;
		return (nx < {1'b0, dim}) ? nx[DIM_W-1:0] : dim;
	endfunction

endpackage

### rtl/gtsp_req_if.sv
// request channel of the tile planner: valid/ready plus the request fields
// depends on gtsp_pkg
`timescale 1ns / 1ps

interface gtsp_req_if import gtsp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [DIM_W-1:0]    rows_m;
	logic [DIM_W-1:0]    cols_n;
	logic [DIM_W-1:0]    depth_k;
	logic [BUDGET_W-1:0] scratch_budget;

	modport source (output valid, rows_m, cols_n, depth_k, scratch_budget, input ready);
	modport sink (input valid, rows_m, cols_n, depth_k, scratch_budget, output ready);
endinterface

### rtl/gtsp_rsp_if.sv
// result channel of the tile planner: valid/ready plus the chosen tile
// depends on gtsp_pkg
`timescale 1ns / 1ps

interface gtsp_rsp_if import gtsp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [DIM_W-1:0] tile_m;
	logic [DIM_W-1:0] tile_n;
	logic [DIM_W-1:0] tile_k;
	logic [JOB_W-1:0] job_count;

	modport source (output valid, found, tile_m, tile_n, tile_k, job_count, input ready);
	modport sink (input valid, found, tile_m, tile_n, tile_k, job_count, output ready);
endinterface

### rtl/gtsp_div.sv
// restoring divider, one quotient bit per cycle
// depends on gtsp_pkg
`timescale 1ns / 1ps

module gtsp_div import gtsp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIM_W-1:0] divisor,
	output logic [DIV_W-1:0] quotient,
	output logic             done
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W-1:0] shifted;
	logic [DIV_W:0]   diff;

	assign shifted = {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!diff[DIV_W]) begin
				rem_q <= diff[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

### rtl/gtsp_dp.sv
// datapath of the tile planner: candidate counters, fit/work pipeline,
// best-tile registers, job count divider and result register; depends on gtsp_pkg, gtsp_div
`timescale 1ns / 1ps

module gtsp_dp import gtsp_pkg::*; #(
	parameter int PE_DIM    = PE_DIM_DEF,
	parameter int K_STEP    = K_STEP_DEF,
	parameter int ALIGN_PAD = ALIGN_PAD_DEF,
	parameter int MAX_DIM   = MAX_DIM_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output status_t             status,
	input  logic [DIM_W-1:0]    rows_m,
	input  logic [DIM_W-1:0]    cols_n,
	input  logic [DIM_W-1:0]    depth_k,
	input  logic [BUDGET_W-1:0] scratch_budget,
	output logic                found,
	output logic [DIM_W-1:0]    tile_m,
	output logic [DIM_W-1:0]    tile_n,
	output logic [DIM_W-1:0]    tile_k,
	output logic [JOB_W-1:0]    job_count
);

	localparam logic [DIM_W:0]    STEP_MN = (DIM_W + 1)'(PE_DIM);
	localparam logic [DIM_W:0]    STEP_K  = (DIM_W + 1)'(K_STEP);
	localparam logic [NEED_W-1:0] PAD     = NEED_W'(ALIGN_PAD);

	// request and candidate counters
	logic [DIM_W-1:0]    m_q, n_q, k_q;
	logic [BUDGET_W-1:0] bud_q;
	logic [DIM_W-1:0]    mt_q, nt_q, kt_q;

	// stage 1: partial products
	logic                v_s1, full_s1;
	logic [DIM_W-1:0]    mt_s1, nt_s1, kt_s1;
	logic [PROD_W-1:0]   mk_s1, kn_s1, mn_s1;

	// stage 2: fit check and work
	logic                v_s2;
	logic [DIM_W-1:0]    mt_s2, nt_s2, kt_s2;
	logic [WORK_W-1:0]   w_s2;

	// best tile so far
	logic                found_q;
	logic [WORK_W-1:0]   best_w_q;
	logic [DIM_W-1:0]    best_m_q, best_n_q, best_k_q;

	logic [NEED_W-1:0]   need;
	logic                fit;
	logic                better;

	logic [DIV_W-1:0]    div_a;
	logic [DIM_W-1:0]    div_b;
	logic [DIV_W-1:0]    quo;
	logic                div_done;
	logic [JOB_W-1:0]    jobs_q;
	logic [JOB_W+DIV_W-1:0] jobs_prod;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q   <= rows_m;
			n_q   <= cols_n;
			k_q   <= depth_k;
			bud_q <= scratch_budget;
			mt_q  <= cand_first(rows_m, STEP_MN);
			nt_q  <= cand_first(cols_n, STEP_MN);
			kt_q  <= cand_first(depth_k, STEP_K);
		end else if (cmd.step) begin
			// m innermost, then n, then k
			if (mt_q == m_q) begin
				mt_q <= cand_first(m_q, STEP_MN);
				if (nt_q == n_q) begin
					nt_q <= cand_first(n_q, STEP_MN);
					kt_q <= cand_next(kt_q, k_q, STEP_K);
				end else begin
					nt_q <= cand_next(nt_q, n_q, STEP_MN);
				end
			end else begin
				mt_q <= cand_next(mt_q, m_q, STEP_MN);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.step;
			v_s2 <= v_s1 & fit;
		end
	end

	always_ff @(posedge clk) begin
		mt_s1   <= mt_q;
		nt_s1   <= nt_q;
		kt_s1   <= kt_q;
		full_s1 <= (kt_q == k_q) && (nt_q == n_q);
		mk_s1   <= PROD_W'(mt_q) * PROD_W'(kt_q);
		kn_s1   <= PROD_W'(kt_q) * PROD_W'(nt_q);
		mn_s1   <= PROD_W'(mt_q) * PROD_W'(nt_q);
	end

	// scratch need: packed operands, plus accumulator and pad unless full n and k
	always_comb begin
		need = NEED_W'(mk_s1) + NEED_W'(kn_s1);
		if (!full_s1) begin
			need = need + NEED_W'(mn_s1) * NEED_W'(ACC_BYTES) + PAD;
		end
		fit = need <= NEED_W'(bud_q);
	end

	always_ff @(posedge clk) begin
		mt_s2 <= mt_s1;
		nt_s2 <= nt_s1;
		kt_s2 <= kt_s1;
		w_s2  <= WORK_W'(mn_s1) * WORK_W'(kt_s1);
	end

	// candidates arrive in increasing (k, n, m) order, so an equal work wins the tie
	assign better = v_s2 && (!found_q || (w_s2 >= best_w_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.load) begin
			found_q <= 1'b0;
		end else if (better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (better) begin
			best_w_q <= w_s2;
			best_m_q <= mt_s2;
			best_n_q <= nt_s2;
			best_k_q <= kt_s2;
		end
	end

	// ceiling division operands
	always_comb begin
		case (cmd.div_sel)
			SEL_M: begin
				div_a = {1'b0, m_q} + {1'b0, best_m_q} - DIV_W'(1);
				div_b = best_m_q;
			end
			SEL_N: begin
				div_a = {1'b0, n_q} + {1'b0, best_n_q} - DIV_W'(1);
				div_b = best_n_q;
			end
			SEL_K: begin
				div_a = {1'b0, k_q} + {1'b0, best_k_q} - DIV_W'(1);
				div_b = best_k_q;
			end
			default: begin
				div_a = '0;
				div_b = '1;
			end
		endcase
	end

	gtsp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.quotient (quo),
		.done     (div_done)
	);

	assign jobs_prod = (JOB_W + DIV_W)'(jobs_q) * (JOB_W + DIV_W)'(quo);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			jobs_q <= JOB_W'(1);
		end else if (cmd.mul) begin
			jobs_q <= (jobs_prod > (JOB_W + DIV_W)'(JOB_MAX)) ? JOB_MAX : jobs_prod[JOB_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			found     <= found_q;
			tile_m    <= found_q ? best_m_q : '0;
			tile_n    <= found_q ? best_n_q : '0;
			tile_k    <= found_q ? best_k_q : '0;
			job_count <= found_q ? jobs_q : '0;
		end
	end

	always_comb begin
		status.invalid   = (m_q == '0) || (n_q == '0) || (k_q == '0) ||
			(32'(m_q) > MAX_DIM) || (32'(n_q) > MAX_DIM) || (32'(k_q) > MAX_DIM);
		status.last_cand = (mt_q == m_q) && (nt_q == n_q) && (kt_q == k_q);
		status.pipe_busy = v_s1 | v_s2;
		status.found     = found_q;
		status.div_done  = div_done;
	end

endmodule

### rtl/gtsp_ctrl.sv
// controller of the tile planner: request intake, search sweep, drain,
// job count sequence and result handoff; depends on gtsp_pkg
`timescale 1ns / 1ps

module gtsp_ctrl import gtsp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output cmd_t    cmd,
	input  status_t status
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SEARCH,
		ST_DRAIN,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_MUL,
		ST_FINISH
	} state_t;

	state_t   state_q;
	dim_sel_t sel_q;
	logic     out_valid_q;

	always_comb begin
		cmd.load      = in_valid && (state_q == ST_IDLE);
		cmd.step      = (state_q == ST_SEARCH);
		cmd.div_start = (state_q == ST_DIV_START);
		cmd.div_sel   = sel_q;
		cmd.mul       = (state_q == ST_MUL);
		cmd.out_load  = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= SEL_M;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= status.invalid ? ST_FINISH : ST_SEARCH;
				end
				ST_SEARCH: begin
					if (status.last_cand) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!status.pipe_busy) begin
						sel_q   <= SEL_M;
						state_q <= status.found ? ST_DIV_START : ST_FINISH;
					end
				end
				ST_DIV_START: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (status.div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					case (sel_q)
						SEL_M: begin
							sel_q   <= SEL_N;
							state_q <= ST_DIV_START;
						end
						SEL_N: begin
							sel_q   <= SEL_K;
							state_q <= ST_DIV_START;
						end
						default: begin
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_FINISH: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

### rtl/gemm_tile_size_planner_unit.sv
// top level of the matrix-multiply tile size planner
// depends on gtsp_pkg, gtsp_req_if, gtsp_rsp_if, gtsp_ctrl, gtsp_dp
`timescale 1ns / 1ps

// Plans the tiling of one matrix multiply per request. A request carries the
// output size rows_m x cols_n, the inner dimension depth_k and a scratch budget
// in bytes; the result gives found, the chosen tile_m/tile_n/tile_k and the
// number of tile jobs. Candidate tile sizes are the multiples of PE_DIM (m, n)
// or K_STEP (k) below the dimension, plus the full dimension. A tile fits when
// its packed operands, plus a 4-byte-per-element accumulator and ALIGN_PAD unless
// the tile covers full n and full k, stay within budget; the largest m*n*k wins,
// ties going to larger k, then n, then m. A zero dimension, one above MAX_DIM,
// or no fitting tile returns found = 0 with all fields zero; job_count saturates
// at 4095. Requests are handled one at a time. The search sweep issues one
// candidate per clock into the fit/compare pipeline, over all candidate tiles (the
// product of the candidate counts of the three dimensions, 2048 for 256 x 256 x
// 256 at the defaults), and the job count then takes three ceiling divisions on
// a shared bit-serial divider. An invalid request skips the search and goes
// straight to the result. A finished result sits in an output register, so the
// next request is taken as soon as the result is loaded, even while that result
// still waits on rsp.
module gemm_tile_size_planner_unit import gtsp_pkg::*; #(
	parameter int PE_DIM    = PE_DIM_DEF,
	parameter int K_STEP    = K_STEP_DEF,
	parameter int ALIGN_PAD = ALIGN_PAD_DEF,
	parameter int MAX_DIM   = MAX_DIM_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	gtsp_req_if.sink   req,
	gtsp_rsp_if.source rsp
);

	// command and status bundles between controller and datapath
	cmd_t    cmd;
	status_t status;

	// controller: owns request/result handshakes and sequencing
	gtsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// datapath: candidate sweep, fit check, best tile, job count, result register
	gtsp_dp #(
		.PE_DIM    (PE_DIM),
		.K_STEP    (K_STEP),
		.ALIGN_PAD (ALIGN_PAD),
		.MAX_DIM   (MAX_DIM)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.rows_m         (req.rows_m),
		.cols_n         (req.cols_n),
		.depth_k        (req.depth_k),
		.scratch_budget (req.scratch_budget),
		.found          (rsp.found),
		.tile_m         (rsp.tile_m),
		.tile_n         (rsp.tile_n),
		.tile_k         (rsp.tile_k),
		.job_count      (rsp.job_count)
	);

endmodule

### rtl/gtsp_checker.sv
// port-level checks of the tile planner, bound to the top level
// depends on gtsp_pkg, assert_macros.svh, gemm_tile_size_planner_unit
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gtsp_checker import gtsp_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic             found,
	input logic [DIM_W-1:0] tile_m,
	input logic [DIM_W-1:0] tile_n,
	input logic [DIM_W-1:0] tile_k,
	input logic [JOB_W-1:0] job_count
);

	// a waiting result holds
	`GTSP_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(found) && $stable(tile_m) && $stable(tile_n) && $stable(tile_k) && $stable(job_count))

	// not found means an all-zero result
	`GTSP_ASSERT_NOW(a_miss_zero, clk, arst_n, rsp_valid && !found, tile_m == '0 && tile_n == '0 && tile_k == '0 && job_count == '0)

	// a found tile is never empty and has at least one job
	`GTSP_ASSERT_NOW(a_hit_nonzero, clk, arst_n, rsp_valid && found, tile_m != '0 && tile_n != '0 && tile_k != '0 && job_count != '0)

	// one request in flight: intake closes right after a request
	`GTSP_ASSERT_NEXT(a_one_req, clk, arst_n, req_valid && req_ready, !req_ready)

endmodule

bind gemm_tile_size_planner_unit gtsp_checker u_gtsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.found     (rsp.found),
	.tile_m    (rsp.tile_m),
	.tile_n    (rsp.tile_n),
	.tile_k    (rsp.tile_k),
	.job_count (rsp.job_count)
);
